// ===== sv/pwd_pkg.sv =====
package pwd_pkg;

    // Ring depth default and register reset values
    localparam int HISTORY_DEPTH_DEF = 64;

    localparam int WINDOW_W = 7;
    localparam int LIMIT_W  = 32;
    localparam int FLOOR_W  = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd20;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 32'd20000;
    localparam logic [FLOOR_W-1:0]  FLOOR_RESET  = 16'd10;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 2'd2;

    // Counter samples and stream widths
    localparam int CNT_W      = 64;
    localparam int KIND_W     = 3;
    localparam int IN_DATA_W  = 2 * CNT_W;
    localparam int OUT_DATA_W = ((1 + 2 * CNT_W + 7) / 8) * 8;

    // Wedge classification codes
    localparam logic [KIND_W-1:0] KIND_HEALTHY = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREEZE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STORM   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SLOW    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FATAL   = 3'd4;

    // Divider iterations: one quotient bit per step
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Shared subtractor result
    typedef struct packed {
        logic             borrow;
        logic [CNT_W:0]   diff;
    } sub_res_t;

endpackage

// ===== sv/progress_wedge_detector.sv =====
// Channel   | Handshake          | Contents (lowest bit first)
// ----------+--------------------+-------------------------------------------------
// s_*       | s_tvalid/s_tready  | tuser: command; tdata: frame sample, reentry sample
// m_*       | m_tvalid/m_tready  | tuser: kind code; tdata: dump_fire,
//           |                    |   frame_progress, reentry_progress, zero pad
// cfg_*     | cfg_we             | cfg_addr: register index; cfg_data: value
//
// A tick with a full window passes through the frame and reentry difference states
// and 64 divider steps on the single shared 65-bit subtractor, then is classified
// and held in the output register.
// Fatal and not-full ticks go straight to classification; frozen ticks skip the divider.
// The input is ready only while the sequencer is idle; a finished result waits in
// the output register while the next item is already taken in.
// rst_n clears the sequencer, pointers, fill level and dump flags at once; the
// history RAM is not cleared, since only written entries are ever read.
module progress_wedge_detector
    import pwd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // frame sample, reentry sample
    input  logic                  s_tuser,   // command
    // master side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // dump_fire, frame_progress,
                                             // reentry_progress, zero pad
    output logic [KIND_W-1:0]     m_tuser,   // kind code
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int WIN_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W = (WIN_W > WINDOW_W) ? WIN_W : WINDOW_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FDIFF = 5'b00010,
        S_RDIFF = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [WINDOW_W-1:0] window_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [FLOOR_W-1:0]  floor_reg;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [WIN_W-1:0] fill_reg, fill_next;
    logic             armed_reg, armed_next;
    logic             fatal_taken_reg, fatal_taken_next;
    logic             fatal_reg;
    logic             full_reg;

    logic [CNT_W-1:0] frame_new_reg, reentry_new_reg;
    logic [CNT_W-1:0] fdelta_reg, rdelta_reg;
    logic [CNT_W-1:0] rem_reg, quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic                  m_valid_reg;
    logic [KIND_W-1:0]     m_kind_reg;
    logic                  m_fire_reg;
    logic [CNT_W-1:0]      m_fprog_reg, m_rprog_reg;

    logic [CMP_W-1:0] win_ext, win_clamp;
    logic [WIN_W-1:0] win, wp_inc, fill_inc;
    logic [PTR_W-1:0] oldest;
    logic             full_now;
    logic             accept, accept_tick;
    logic             out_free;

    logic [IN_DATA_W-1:0] ram_rdata;
    logic [CNT_W:0]       sub_a, sub_b;
    sub_res_t             sub_res;

    logic [KIND_W-1:0] kind;
    logic              fire;

    assign s_tready    = (state_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign accept_tick = accept && !s_tuser;
    assign out_free    = !m_valid_reg || m_tready;

    // Clamp the window to [2, HISTORY_DEPTH]
    always_comb
    begin
        win_ext = CMP_W'(window_reg);
        priority if (win_ext < CMP_W'(2))
        begin
            win_clamp = CMP_W'(2);
        end
        else if (win_ext > CMP_W'(HISTORY_DEPTH))
        begin
            win_clamp = CMP_W'(HISTORY_DEPTH);
        end
        else
        begin
            win_clamp = win_ext;
        end
        win = win_clamp[WIN_W-1:0];
    end

    // Ring pointers: oldest entry of the window and next write slot
    always_comb
    begin
        wp_inc = WIN_W'(wp_reg) + WIN_W'(1);
        if (wp_inc >= win)
        begin
            oldest = PTR_W'(wp_inc - win);
        end
        else
        begin
            oldest = PTR_W'(wp_inc + WIN_W'(HISTORY_DEPTH) - win);
        end
        wp_next  = (wp_inc == WIN_W'(HISTORY_DEPTH)) ? '0 : PTR_W'(wp_inc);
        fill_inc = (fill_reg < WIN_W'(HISTORY_DEPTH)) ? fill_reg + WIN_W'(1) : fill_reg;
        full_now = (fill_inc >= win);
    end

    // History ring: reentry sample above frame sample
    pwd_ram #(
        .WIDTH (IN_DATA_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (accept_tick),
        .waddr (wp_reg),
        .wdata (s_tdata),
        .re    (accept_tick),
        .raddr (oldest),
        .rdata (ram_rdata)
    );

    // Operand select for the shared subtractor
    always_comb
    begin
        unique case (state_reg)
            S_FDIFF:
            begin
                sub_a = {1'b0, frame_new_reg};
                sub_b = {1'b0, ram_rdata[CNT_W-1:0]};
            end
            S_RDIFF:
            begin
                sub_a = {1'b0, reentry_new_reg};
                sub_b = {1'b0, ram_rdata[IN_DATA_W-1:CNT_W]};
            end
            S_DIV:
            begin
                sub_a = {rem_reg, quo_reg[CNT_W-1]};
                sub_b = {1'b0, fdelta_reg};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    pwd_sub u_sub (
        .a   (sub_a),
        .b   (sub_b),
        .res (sub_res)
    );

    // Classify the finished item and decide the dump
    always_comb
    begin
        armed_next       = armed_reg;
        fatal_taken_next = fatal_taken_reg;
        fire             = 1'b0;
        priority if (fatal_reg)
        begin
            kind = KIND_FATAL;
        end
        else if (!full_reg)
        begin
            kind = KIND_HEALTHY;
        end
        else if (fdelta_reg == '0)
        begin
            kind = KIND_FREEZE;
        end
        else if (quo_reg > CNT_W'(limit_reg))
        begin
            kind = KIND_STORM;
        end
        else if (fdelta_reg < CNT_W'(floor_reg))
        begin
            kind = KIND_SLOW;
        end
        else
        begin
            kind = KIND_HEALTHY;
        end

        priority if (fatal_reg)
        begin
            if (!fatal_taken_reg)
            begin
                fire             = 1'b1;
                fatal_taken_next = 1'b1;
                armed_next       = 1'b0;
            end
        end
        else if (kind != KIND_HEALTHY)
        begin
            fire       = armed_reg;
            armed_next = 1'b0;
        end
        else
        begin
            armed_next = 1'b1;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_tuser || !full_now) ? S_DONE : S_FDIFF;
                end
            end
            S_FDIFF:
            begin
                state_next = S_RDIFF;
            end
            S_RDIFF:
            begin
                state_next = (fdelta_reg == '0) ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            wp_reg          <= '0;
            fill_reg        <= '0;
            armed_reg       <= 1'b1;
            fatal_taken_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            window_reg      <= WINDOW_RESET;
            limit_reg       <= LIMIT_RESET;
            floor_reg       <= FLOOR_RESET;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_WINDOW: window_reg <= cfg_data[WINDOW_W-1:0];
                    CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                    CFG_FLOOR:  floor_reg  <= cfg_data[FLOOR_W-1:0];
                    default:    ;
                endcase
            end

            // Advance the ring on each tick
            if (accept_tick)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end

            // Hand the result to the output register, drop it once transferred
            if (state_reg == S_DONE && out_free)
            begin
                m_valid_reg     <= 1'b1;
                armed_reg       <= armed_next;
                fatal_taken_reg <= fatal_taken_next;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign fill_next = fill_inc;

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fatal_reg       <= s_tuser;
                    full_reg        <= full_now;
                    frame_new_reg   <= s_tdata[CNT_W-1:0];
                    reentry_new_reg <= s_tdata[IN_DATA_W-1:CNT_W];
                    fdelta_reg      <= '0;
                    rdelta_reg      <= '0;
                    quo_reg         <= '0;
                end
            end
            S_FDIFF:
            begin
                fdelta_reg <= sub_res.borrow ? '0 : sub_res.diff[CNT_W-1:0];
            end
            S_RDIFF:
            begin
                rdelta_reg <= sub_res.borrow ? '0 : sub_res.diff[CNT_W-1:0];
                quo_reg    <= sub_res.borrow ? '0 : sub_res.diff[CNT_W-1:0];
                rem_reg    <= '0;
                cnt_reg    <= '0;
            end
            S_DIV:
            begin
                // Restoring divide step: keep the difference unless it borrowed
                if (sub_res.borrow)
                begin
                    rem_reg <= {rem_reg[CNT_W-2:0], quo_reg[CNT_W-1]};
                    quo_reg <= {quo_reg[CNT_W-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= sub_res.diff[CNT_W-1:0];
                    quo_reg <= {quo_reg[CNT_W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_kind_reg  <= kind;
                    m_fire_reg  <= fire;
                    m_fprog_reg <= fdelta_reg;
                    m_rprog_reg <= rdelta_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output port
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {{(OUT_DATA_W - 1 - 2 * CNT_W){1'b0}}, m_rprog_reg, m_fprog_reg,
                       m_fire_reg};

    // A dump never fires on a healthy result
    a_fire_not_healthy: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_fire_reg |-> m_kind_reg != KIND_HEALTHY)
        else $error("dump fired on a healthy result");

    // The divider only runs with a nonzero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> fdelta_reg != '0)
        else $error("divide started with zero frame progress");

    // The partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < fdelta_reg)
        else $error("divider remainder out of range");

    // The fill level never passes the ring depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept_tick |=> fill_reg <= WIN_W'(HISTORY_DEPTH) && fill_reg != '0)
        else $error("fill level out of range after a tick");

endmodule

// ===== sv/pwd_ram.sv =====
module pwd_ram
    import pwd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pwd_sub.sv =====
module pwd_sub
    import pwd_pkg::*;
(
    input  logic [CNT_W:0] a,
    input  logic [CNT_W:0] b,
    output sub_res_t       res
);

    logic [CNT_W+1:0] full_diff;

    // One wide subtract; the top bit flags a borrow
    always_comb
    begin
        full_diff  = {1'b0, a} - {1'b0, b};
        res.borrow = full_diff[CNT_W+1];
        res.diff   = full_diff[CNT_W:0];
    end

endmodule
